[hw/rtl/nir_pkg.sv]
package nir_pkg;

	// field and register widths
	localparam int unsigned DUR_W     = 16;
	localparam int unsigned CMD_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// frame layout: bits shifted in LSB first, command byte at CMD_LSB
	localparam int unsigned FRAME_BITS = 32;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned CMD_LSB    = 8;

	// fixed header mark window
	localparam logic [DUR_W-1:0] HDR_MARK_MIN = 16'd8500;
	localparam logic [DUR_W-1:0] HDR_MARK_MAX = 16'd9500;

	// register reset values
	localparam logic [DUR_W-1:0] RST_HDR_SPACE_MIN  = 16'd4000;
	localparam logic [DUR_W-1:0] RST_HDR_SPACE_MAX  = 16'd5000;
	localparam logic [DUR_W-1:0] RST_BIT_MARK_MIN   = 16'd400;
	localparam logic [DUR_W-1:0] RST_BIT_MARK_MAX   = 16'd700;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MIN = 16'd300;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MAX = 16'd800;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE_MIN  = 16'd1300;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE_MAX  = 16'd2200;

	// queue between classifier and frame machine
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HDR_SPACE_MIN  = 3'd0,
		REG_HDR_SPACE_MAX  = 3'd1,
		REG_BIT_MARK_MIN   = 3'd2,
		REG_BIT_MARK_MAX   = 3'd3,
		REG_ZERO_SPACE_MIN = 3'd4,
		REG_ZERO_SPACE_MAX = 3'd5,
		REG_ONE_SPACE_MIN  = 3'd6,
		REG_ONE_SPACE_MAX  = 3'd7
	} cfg_idx_t;

	// window hits of one pulse
	typedef struct packed {
		logic hdr_mark_ok;
		logic hdr_space_ok;
		logic bit_mark_ok;
		logic one_ok;
		logic zero_ok;
	} pulse_class_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// open window test: lo < d < hi
	function automatic logic in_window(
		input logic [DUR_W-1:0] d,
		input logic [DUR_W-1:0] lo,
		input logic [DUR_W-1:0] hi
	);
		return (d > lo) && (d < hi);
	endfunction

endpackage

[hw/rtl/nir_front.sv]
module nir_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nir_pkg::DUR_W-1:0]      duration_us,
	input  logic                           cfg_wen,
	input  logic [nir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nir_pkg::DUR_W-1:0]      cfg_data,
	input  nir_pkg::queue_status_t         q_status,
	output logic                           push,
	output nir_pkg::pulse_class_t          push_class
);

	logic [nir_pkg::DUR_W-1:0] hdr_space_min_q;
	logic [nir_pkg::DUR_W-1:0] hdr_space_max_q;
	logic [nir_pkg::DUR_W-1:0] bit_mark_min_q;
	logic [nir_pkg::DUR_W-1:0] bit_mark_max_q;
	logic [nir_pkg::DUR_W-1:0] zero_space_min_q;
	logic [nir_pkg::DUR_W-1:0] zero_space_max_q;
	logic [nir_pkg::DUR_W-1:0] one_space_min_q;
	logic [nir_pkg::DUR_W-1:0] one_space_max_q;

	// write window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_space_min_q  <= nir_pkg::RST_HDR_SPACE_MIN;
			hdr_space_max_q  <= nir_pkg::RST_HDR_SPACE_MAX;
			bit_mark_min_q   <= nir_pkg::RST_BIT_MARK_MIN;
			bit_mark_max_q   <= nir_pkg::RST_BIT_MARK_MAX;
			zero_space_min_q <= nir_pkg::RST_ZERO_SPACE_MIN;
			zero_space_max_q <= nir_pkg::RST_ZERO_SPACE_MAX;
			one_space_min_q  <= nir_pkg::RST_ONE_SPACE_MIN;
			one_space_max_q  <= nir_pkg::RST_ONE_SPACE_MAX;
		end else if (cfg_wen) begin
			unique case (nir_pkg::cfg_idx_t'(cfg_index))
				nir_pkg::REG_HDR_SPACE_MIN:  hdr_space_min_q  <= cfg_data;
				nir_pkg::REG_HDR_SPACE_MAX:  hdr_space_max_q  <= cfg_data;
				nir_pkg::REG_BIT_MARK_MIN:   bit_mark_min_q   <= cfg_data;
				nir_pkg::REG_BIT_MARK_MAX:   bit_mark_max_q   <= cfg_data;
				nir_pkg::REG_ZERO_SPACE_MIN: zero_space_min_q <= cfg_data;
				nir_pkg::REG_ZERO_SPACE_MAX: zero_space_max_q <= cfg_data;
				nir_pkg::REG_ONE_SPACE_MIN:  one_space_min_q  <= cfg_data;
				nir_pkg::REG_ONE_SPACE_MAX:  one_space_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the pulse against every window
	always_comb begin
		push_class.hdr_mark_ok  = nir_pkg::in_window(duration_us,
			nir_pkg::HDR_MARK_MIN, nir_pkg::HDR_MARK_MAX);
		push_class.hdr_space_ok = nir_pkg::in_window(duration_us,
			hdr_space_min_q, hdr_space_max_q);
		push_class.bit_mark_ok  = nir_pkg::in_window(duration_us,
			bit_mark_min_q, bit_mark_max_q);
		push_class.one_ok       = nir_pkg::in_window(duration_us,
			one_space_min_q, one_space_max_q);
		push_class.zero_ok      = nir_pkg::in_window(duration_us,
			zero_space_min_q, zero_space_max_q);
	end

	// accept a beat whenever the queue has room
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

endmodule

[hw/rtl/nir_queue.sv]
module nir_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  nir_pkg::pulse_class_t  push_class,
	input  logic                   pop,
	output nir_pkg::pulse_class_t  pop_class,
	output nir_pkg::queue_status_t q_status
);

	nir_pkg::pulse_class_t             mem_q [nir_pkg::QUEUE_DEPTH];
	logic [nir_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [nir_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [nir_pkg::QCNT_W-1:0]        count_q;

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_class;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + nir_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + nir_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + nir_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - nir_pkg::QCNT_W'(1);
			end
		end
	end

	assign pop_class      = mem_q[rd_ptr_q];
	assign q_status.full  = (count_q == nir_pkg::QCNT_W'(nir_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

[hw/rtl/nir_back.sv]
module nir_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nir_pkg::queue_status_t     q_status,
	input  nir_pkg::pulse_class_t      pop_class,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [nir_pkg::CMD_W-1:0]  command_code,
	output logic                       frame_done
);

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_HDR_SPACE = 2'd1,
		PH_BIT_MARK  = 2'd2,
		PH_BIT_SPACE = 2'd3
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [nir_pkg::CNT_W-1:0]    bit_count_q, bit_count_d, cnt_inc;
	logic [nir_pkg::CMD_W-1:0]    cmd_shift_q, cmd_shift_d;
	logic [nir_pkg::CMD_W-1:0]    held_q, held_d;
	logic                         done_d;
	logic                         out_valid_q;
	logic [nir_pkg::CMD_W-1:0]    command_q;
	logic                         done_q;

	// take the next entry when the output register is free or draining
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	assign cnt_inc = bit_count_q + nir_pkg::CNT_W'(1);

	// frame machine next state
	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		cmd_shift_d = cmd_shift_q;
		held_d      = held_q;
		done_d      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (pop_class.hdr_mark_ok) begin
					phase_d = PH_HDR_SPACE;
				end
			end
			PH_HDR_SPACE: begin
				if (pop_class.hdr_space_ok) begin
					cmd_shift_d = '0;
					bit_count_d = '0;
					phase_d     = PH_BIT_MARK;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_BIT_MARK: begin
				phase_d = pop_class.bit_mark_ok ? PH_BIT_SPACE : PH_IDLE;
			end
			PH_BIT_SPACE: begin
				if (pop_class.one_ok || pop_class.zero_ok) begin
					// only the command byte of the frame is kept
					for (int i = 0; i < nir_pkg::CMD_W; i++) begin
						if (bit_count_q == nir_pkg::CNT_W'(nir_pkg::CMD_LSB + i)) begin
							cmd_shift_d[i] = pop_class.one_ok;
						end
					end
					bit_count_d = cnt_inc;
					if (cnt_inc >= nir_pkg::CNT_W'(nir_pkg::FRAME_BITS)) begin
						held_d  = cmd_shift_d;
						done_d  = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_BIT_MARK;
					end
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// hold state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			cmd_shift_q <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			command_q   <= '0;
			done_q      <= 1'b0;
		end else if (pop) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			cmd_shift_q <= cmd_shift_d;
			held_q      <= held_d;
			out_valid_q <= 1'b1;
			command_q   <= held_d;
			done_q      <= done_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = command_q;
	assign frame_done   = done_q;

endmodule

[hw/rtl/nec_ir_pulse_decoder.sv]
// Channel   Direction  Handshake            Beat payload
// in        input      in_valid / in_stall   duration_us[15:0]
// out       output     out_valid / out_stall command_code[7:0], frame_done
// cfg       input      cfg_wen               cfg_index[2:0], cfg_data[15:0]
//
// One beat per cycle is taken and one result per cycle is given, sustained, while out_stall is low.
// An accepted beat is first written into the queue; the frame machine pops it once earlier entries
// are gone and the output register is free or draining, and then registers its result.
// The four-entry queue lets input keep flowing while the output is stalled;
// in_stall rises only when the queue is full.
// Reset loads the default windows, empties the queue and idles the machine.
module nec_ir_pulse_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nir_pkg::DUR_W-1:0]      duration_us,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nir_pkg::CMD_W-1:0]      command_code,
	output logic                           frame_done,
	input  logic                           cfg_wen,
	input  logic [nir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nir_pkg::DUR_W-1:0]      cfg_data
);

	nir_pkg::queue_status_t q_status;
	nir_pkg::pulse_class_t  push_class;
	nir_pkg::pulse_class_t  pop_class;
	logic                   push;
	logic                   pop;

	nir_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.duration_us(duration_us),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.push_class (push_class)
	);

	nir_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_class(push_class),
		.pop       (pop),
		.pop_class (pop_class),
		.q_status  (q_status)
	);

	nir_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_class   (pop_class),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command_code(command_code),
		.frame_done  (frame_done)
	);

endmodule

[hw/rtl/nir_checker.sv]
module nir_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [nir_pkg::CMD_W-1:0]      command_code,
	input logic                           frame_done
);

	logic                        in_beat;
	logic                        out_beat;
	logic [3:0]                  pending_q;
	logic [nir_pkg::CMD_W-1:0]   last_cmd_q;
	logic                        last_done_q;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// track beats in flight and the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			last_cmd_q  <= '0;
			last_done_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 4'(in_beat) - 4'(out_beat);
			if (out_beat) begin
				last_cmd_q  <= command_code;
				last_done_q <= frame_done;
			end
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(command_code) && $stable(frame_done))
		else $error("stalled result changed");

	// no result without an earlier accepted pulse
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a pending pulse");

	// held command only changes on a completed frame
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> command_code == last_cmd_q)
		else $error("command changed without a frame");

	// a frame takes many pulses, so completions never abut
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_done_q |-> !frame_done)
		else $error("back-to-back frame completions");

endmodule

bind nec_ir_pulse_decoder nir_checker u_nir_checker (.*);

[sim/nec_ir_pulse_decoder_tb.sv]
module nec_ir_pulse_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int unsigned LONG_HOLD        = 120;
	localparam int unsigned PULSES_PER_FRAME = 2 + 2 * nir_pkg::FRAME_BITS;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE
	} nec_phase_t;

	// one pulse waiting to be offered, with its idle cycles before it
	typedef struct {
		logic [nir_pkg::DUR_W-1:0] dur;
		int unsigned               gap;
		bit                        drain;
	} pulse_t;

	typedef struct {
		logic [nir_pkg::CMD_W-1:0] cmd;
		logic                      done;
	} decode_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic [nir_pkg::DUR_W-1:0]     duration_us = '0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [nir_pkg::CMD_W-1:0]     command_code;
	logic                          frame_done;
	logic                          cfg_wen     = 1'b0;
	logic [nir_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
	logic [nir_pkg::DUR_W-1:0]     cfg_data    = '0;

	pulse_t  pulse_plan[$];
	decode_t expected_decodes[$];

	// decoder mirror: windows, frame machine, held command
	logic [nir_pkg::DUR_W-1:0]      win_limit [8];
	nec_phase_t                     mir_phase;
	logic [nir_pkg::FRAME_BITS-1:0] mir_frame;
	logic [nir_pkg::CNT_W-1:0]      mir_count;
	logic [nir_pkg::CMD_W-1:0]      mir_cmd;

	logic [nir_pkg::DUR_W-1:0] plan_limit [8];

	bit          in_taken    = 1'b0;
	bit          out_taken   = 1'b0;
	bit          tx_loaded   = 1'b0;
	bit          tx_busy     = 1'b0;
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;
	pulse_t      tx_item;
	int unsigned tx_gap      = 0;
	int unsigned rx_wait     = 0;
	int unsigned hold_req    = 0;
	int unsigned hold_ack    = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;

	nec_ir_pulse_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.duration_us  (duration_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code),
		.frame_done   (frame_done),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit strictly_between(input logic [nir_pkg::DUR_W-1:0] d,
			input logic [nir_pkg::DUR_W-1:0] lo, input logic [nir_pkg::DUR_W-1:0] hi);
		return (d > lo) && (d < hi);
	endfunction

	// advance the frame machine by one pulse and return the result beat
	function automatic decode_t decode_pulse(input logic [nir_pkg::DUR_W-1:0] d);
		decode_t r;
		bit      hit;
		r.done = 1'b0;
		case (mir_phase)
			PH_IDLE: begin
				if (strictly_between(d, nir_pkg::HDR_MARK_MIN, nir_pkg::HDR_MARK_MAX))
					mir_phase = PH_HDR_SPACE;
			end
			PH_HDR_SPACE: begin
				if (strictly_between(d, win_limit[nir_pkg::REG_HDR_SPACE_MIN],
						win_limit[nir_pkg::REG_HDR_SPACE_MAX])) begin
					mir_frame = '0;
					mir_count = '0;
					mir_phase = PH_BIT_MARK;
				end else begin
					mir_phase = PH_IDLE;
				end
			end
			PH_BIT_MARK: begin
				mir_phase = strictly_between(d, win_limit[nir_pkg::REG_BIT_MARK_MIN],
					win_limit[nir_pkg::REG_BIT_MARK_MAX]) ? PH_BIT_SPACE : PH_IDLE;
			end
			PH_BIT_SPACE: begin
				// one window takes priority over zero window
				hit = 1'b1;
				if (strictly_between(d, win_limit[nir_pkg::REG_ONE_SPACE_MIN],
						win_limit[nir_pkg::REG_ONE_SPACE_MAX]))
					mir_frame[mir_count[4:0]] = 1'b1;
				else if (strictly_between(d, win_limit[nir_pkg::REG_ZERO_SPACE_MIN],
						win_limit[nir_pkg::REG_ZERO_SPACE_MAX]))
					mir_frame[mir_count[4:0]] = 1'b0;
				else
					hit = 1'b0;
				if (!hit) begin
					mir_phase = PH_IDLE;
				end else begin
					mir_count = mir_count + 1'b1;
					if (mir_count >= nir_pkg::FRAME_BITS) begin
						mir_cmd   = mir_frame[nir_pkg::CMD_LSB +: nir_pkg::CMD_W];
						r.done    = 1'b1;
						mir_phase = PH_IDLE;
					end else begin
						mir_phase = PH_BIT_MARK;
					end
				end
			end
		endcase
		r.cmd = mir_cmd;
		return r;
	endfunction

	function automatic void note_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		fail_count++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	// sample both channels and config writes; predict and check
	always @(posedge clk) begin
		decode_t got;
		decode_t want;
		cycle_count++;
		in_taken  = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (!arst_n) begin
			win_limit[nir_pkg::REG_HDR_SPACE_MIN]  = nir_pkg::RST_HDR_SPACE_MIN;
			win_limit[nir_pkg::REG_HDR_SPACE_MAX]  = nir_pkg::RST_HDR_SPACE_MAX;
			win_limit[nir_pkg::REG_BIT_MARK_MIN]   = nir_pkg::RST_BIT_MARK_MIN;
			win_limit[nir_pkg::REG_BIT_MARK_MAX]   = nir_pkg::RST_BIT_MARK_MAX;
			win_limit[nir_pkg::REG_ZERO_SPACE_MIN] = nir_pkg::RST_ZERO_SPACE_MIN;
			win_limit[nir_pkg::REG_ZERO_SPACE_MAX] = nir_pkg::RST_ZERO_SPACE_MAX;
			win_limit[nir_pkg::REG_ONE_SPACE_MIN]  = nir_pkg::RST_ONE_SPACE_MIN;
			win_limit[nir_pkg::REG_ONE_SPACE_MAX]  = nir_pkg::RST_ONE_SPACE_MAX;
			mir_phase = PH_IDLE;
			mir_frame = '0;
			mir_count = '0;
			mir_cmd   = '0;
		end else begin
			if (cfg_wen)
				win_limit[cfg_index] = cfg_data;
			if (in_taken)
				expected_decodes.push_back(decode_pulse(duration_us));
			if (out_taken) begin
				got.cmd  = command_code;
				got.done = frame_done;
				if (expected_decodes.size() == 0) begin
					fail_count++;
					$error("result beat with nothing expected: command_code %0d frame_done %0d",
						got.cmd, got.done);
				end else begin
					want = expected_decodes.pop_front();
					if (got.cmd !== want.cmd)
						note_mismatch("command_code", want.cmd, got.cmd);
					if (got.done !== want.done)
						note_mismatch("frame_done", want.done, got.done);
				end
			end
		end
	end

	// offer pulses from the plan; hold the beat until taken
	always @(negedge clk) begin
		logic                      nv;
		logic [nir_pkg::DUR_W-1:0] nd;
		nv = in_valid;
		nd = duration_us;
		if (in_taken)
			nv = 1'b0;
		if (arst_n && !nv) begin
			if (!tx_loaded && pulse_plan.size() > 0 &&
					(!pulse_plan[0].drain || expected_decodes.size() == 0)) begin
				tx_item   = pulse_plan.pop_front();
				tx_gap    = tx_item.gap;
				tx_loaded = 1'b1;
			end
			if (tx_loaded) begin
				if (tx_gap == 0) begin
					nv        = 1'b1;
					nd        = tx_item.dur;
					tx_loaded = 1'b0;
				end else begin
					tx_gap--;
				end
			end
		end
		tx_busy = nv || tx_loaded;
		in_valid    <= nv;
		duration_us <= nd;
	end

	// stall the result side: random wait per beat, long hold on request
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
		end
		if (hold_ack != hold_req) begin
			hold_ack++;
			rx_wait = LONG_HOLD;
		end
		if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void push_pulse(input logic [nir_pkg::DUR_W-1:0] d,
			input bit burst = 1'b0, input bit drain = 1'b0);
		pulse_t p;
		if ($urandom_range(0, 47) == 0)
			tx_calm = !tx_calm;
		p.dur   = d;
		p.gap   = (burst || tx_calm) ? 0 : $urandom_range(0, 11);
		p.drain = drain;
		pulse_plan.push_back(p);
	endfunction

	// random duration strictly inside lo..hi, or lo when the window is empty
	function automatic logic [nir_pkg::DUR_W-1:0] pick_in(input int unsigned lo,
			input int unsigned hi);
		if (hi > lo + 1)
			return nir_pkg::DUR_W'($urandom_range(lo + 1, hi - 1));
		return nir_pkg::DUR_W'(lo);
	endfunction

	// queue one frame with random content; a broken one is corrupted or cut short
	function automatic int unsigned push_frame(input bit broken, input bit burst);
		logic [nir_pkg::DUR_W-1:0]      seq [PULSES_PER_FRAME];
		logic [nir_pkg::FRAME_BITS-1:0] word;
		int unsigned                    n;
		int unsigned                    cut;
		bit                             drain;
		word   = nir_pkg::FRAME_BITS'($urandom());
		seq[0] = pick_in(nir_pkg::HDR_MARK_MIN, nir_pkg::HDR_MARK_MAX);
		seq[1] = pick_in(win_limit[nir_pkg::REG_HDR_SPACE_MIN],
			win_limit[nir_pkg::REG_HDR_SPACE_MAX]);
		for (int b = 0; b < nir_pkg::FRAME_BITS; b++) begin
			seq[2 + 2 * b] = pick_in(win_limit[nir_pkg::REG_BIT_MARK_MIN],
				win_limit[nir_pkg::REG_BIT_MARK_MAX]);
			seq[3 + 2 * b] = word[b] ?
				pick_in(win_limit[nir_pkg::REG_ONE_SPACE_MIN],
					win_limit[nir_pkg::REG_ONE_SPACE_MAX]) :
				pick_in(win_limit[nir_pkg::REG_ZERO_SPACE_MIN],
					win_limit[nir_pkg::REG_ZERO_SPACE_MAX]);
		end
		n = PULSES_PER_FRAME;
		if (broken) begin
			cut = $urandom_range(0, n - 1);
			case ($urandom_range(0, 2))
				0:       seq[cut] = nir_pkg::DUR_W'($urandom());
				1:       seq[cut] = win_limit[$urandom_range(0, 7)];
				default: n = cut;
			endcase
		end
		drain = !burst && ($urandom_range(0, 24) == 0);
		for (int i = 0; i < n; i++)
			push_pulse(seq[i], burst, drain && (i == 0));
		return n;
	endfunction

	function automatic void push_noise();
		int unsigned n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0:       push_pulse('0);
				1:       push_pulse('1);
				2:       push_pulse(nir_pkg::DUR_W'($urandom()));
				3:       push_pulse(win_limit[$urandom_range(0, 7)]);
				default: push_pulse(nir_pkg::HDR_MARK_MIN +
					nir_pkg::DUR_W'($urandom_range(0, 1000)));
			endcase
		end
	endfunction

	// mostly well-formed frames, some broken ones and a little noise
	task automatic run_traffic(input int unsigned budget);
		int unsigned sent;
		int unsigned pick;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				sent += push_frame(1'b0, 1'b0);
			else if (pick < 17)
				sent += push_frame(1'b1, 1'b0);
			else
				push_noise();
		end
	endtask

	// wait until every planned pulse is taken and every result is back
	task automatic settle();
		while (pulse_plan.size() != 0 || tx_busy || expected_decodes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_windows();
		nir_pkg::cfg_idx_t r;
		r = r.first();
		do begin
			@(negedge clk);
			cfg_wen   <= 1'b1;
			cfg_index <= r;
			cfg_data  <= plan_limit[r];
			r = r.next();
		end while (r != r.first());
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		logic [nir_pkg::DUR_W-1:0] lo;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// header mark: extremes and both bounds
		push_pulse('0);
		push_pulse('1);
		push_pulse(nir_pkg::HDR_MARK_MIN);
		push_pulse(nir_pkg::HDR_MARK_MAX);
		push_pulse(nir_pkg::HDR_MARK_MIN + 1'b1);
		push_pulse(nir_pkg::RST_HDR_SPACE_MIN);
		push_pulse(nir_pkg::HDR_MARK_MAX - 1'b1);
		push_pulse(nir_pkg::RST_HDR_SPACE_MAX);
		// repeat-code header space drops the frame
		push_pulse(16'd9000);
		push_pulse(16'd2250);
		// bit mark at its upper bound
		push_pulse(16'd9000);
		push_pulse(nir_pkg::RST_HDR_SPACE_MIN + 1'b1);
		push_pulse(nir_pkg::RST_BIT_MARK_MAX);
		// space between zero and one windows, then at the one upper bound
		push_pulse(16'd9000);
		push_pulse(nir_pkg::RST_HDR_SPACE_MAX - 1'b1);
		push_pulse(nir_pkg::RST_BIT_MARK_MIN + 1'b1);
		push_pulse(16'd1000);
		push_pulse(16'd9000, 1'b0, 1'b1);
		push_pulse(16'd4500);
		push_pulse(nir_pkg::RST_BIT_MARK_MAX - 1'b1);
		push_pulse(nir_pkg::RST_ONE_SPACE_MAX - 1'b1);
		push_pulse(16'd500);
		push_pulse(nir_pkg::RST_ZERO_SPACE_MIN + 1'b1);
		push_pulse('1);
		push_pulse(nir_pkg::RST_ONE_SPACE_MAX);
		settle();

		// hold the result side while a frame streams in back to back
		hold_req++;
		void'(push_frame(1'b0, 1'b1));
		run_traffic(300);
		settle();

		// overlapping zero and one windows
		plan_limit = '{16'd4000, 16'd5000, 16'd400, 16'd700,
			16'd300, 16'd2000, 16'd1000, 16'd2200};
		program_windows();
		run_traffic(150);
		settle();

		// widest windows
		plan_limit = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
			16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		program_windows();
		run_traffic(150);
		settle();

		// empty bit mark and space windows
		plan_limit = '{16'd4000, 16'd5000, 16'd500, 16'd501,
			16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
		program_windows();
		run_traffic(50);
		settle();

		// random ordered windows
		repeat (2) begin
			for (int k = 0; k < 8; k += 2) begin
				lo              = nir_pkg::DUR_W'($urandom_range(0, 60000));
				plan_limit[k]   = lo;
				plan_limit[k+1] = lo + nir_pkg::DUR_W'($urandom_range(2, 4000));
			end
			program_windows();
			run_traffic(100);
			settle();
		end

		// empty one window: only zeros get through
		plan_limit = '{16'd4000, 16'd5000, 16'd400, 16'd700,
			16'd300, 16'd800, 16'd2200, 16'd1300};
		program_windows();
		run_traffic(60);
		settle();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[nec_ir_pulse_decoder.f]
hw/rtl/nir_pkg.sv
hw/rtl/nir_front.sv
hw/rtl/nir_queue.sv
hw/rtl/nir_back.sv
hw/rtl/nec_ir_pulse_decoder.sv
hw/rtl/nir_checker.sv
sim/nec_ir_pulse_decoder_tb.sv
